[rtl/core/mkbw_pkg.sv]
package mkbw_pkg;

  localparam int PosW  = 32;
  localparam int WidW  = 32;
  localparam int OutW  = 31;
  localparam int NCoef = 12;
  localparam int DefTerms = 12;
  localparam int FracW = 30;
  localparam logic [31:0] WidthReset = 32'd65536;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;
  localparam logic [63:0] DecScale = 64'd1000000000000000000;

  // A_k to 18 places, turned into Q0.32 with round half up
  function automatic logic [31:0] coef(input int k);
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] q;
    begin
      unique case (k)
        1:  n = 64'd114618222126928750;
        2:  n = 64'd282809127387243424;
        3:  n = 64'd310134912036597640;
        4:  n = 64'd191306805797991573;
        5:  n = 64'd75524899698488194;
        6:  n = 64'd20705580068223096;
        7:  n = 64'd4170528248335567;
        8:  n = 64'd643147874291253;
        9:  n = 64'd78365618403163;
        10: n = 64'd7734376522859;
        11: n = 64'd630869723716;
        12: n = 64'd43239129179;
        default: n = 64'd0;
      endcase
      rem = n;
      q = 64'd0;
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= DecScale) begin
          rem = rem - DecScale;
          q[0] = 1'b1;
        end
      end
      if ((rem << 1) >= DecScale) q = q + 64'd1;
      return q[31:0];
    end
  endfunction

  // classified item handed from front to back
  typedef struct packed {
    logic        zero;   // outside window or zero width
    logic [32:0] dbl;    // 2|x|, Q16.16
  } mkbw_item_t;

endpackage

[rtl/core/mkbw_if.sv]
interface mkbw_if #(parameter int W = 32) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/mkbw_front.sv]
module mkbw_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            width,
  mkbw_if.sink                   in_ch,
  output logic                   q_valid,
  input  logic                   q_ready,
  output mkbw_pkg::mkbw_item_t   q_item
);
  import mkbw_pkg::*;

  logic [32:0] mag;
  mkbw_item_t  item_next;

  always_comb begin
    mag = in_ch.data[31] ? (33'h1_0000_0000 - {1'b0, in_ch.data}) : {1'b0, in_ch.data};
    item_next.dbl  = {mag[31:0], 1'b0};
    item_next.zero = (width == 32'd0) || (item_next.dbl >= {1'b0, width});
  end

  assign in_ch.ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ch.ready) begin
      q_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      q_item <= item_next;
    end
  end
endmodule

[rtl/core/mkbw_queue.sv]
module mkbw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mkbw_pkg::mkbw_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mkbw_pkg::mkbw_item_t out_item
);
  import mkbw_pkg::*;

  mkbw_item_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= !wp;
      if (out_valid && out_ready) rp <= !rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
    if (in_valid && in_ready) mem[wp] <= in_item;
  end
endmodule

[rtl/core/mkbw_back.sv]
module mkbw_back #(
  parameter int TERMS = mkbw_pkg::DefTerms
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          width,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  mkbw_pkg::mkbw_item_t q_item,
  mkbw_if.source               out_ch
);
  import mkbw_pkg::*;

  localparam int T = (TERMS > NCoef) ? NCoef : ((TERMS < 1) ? 1 : TERMS);
  localparam int DS = 30;           // quotient bits: ratio below 2^30, 2|x| seeds the remainder
  localparam int HS = T;            // Horner steps
  localparam int NS = DS + 1 + HS;  // stages ahead of the output register
  localparam logic [31:0] KTop = coef(T);

  // stage valid/zero bits
  logic [NS-1:0] vld;
  logic [NS-1:0] zr;
  logic          adv;

  assign adv = !out_ch.valid || out_ch.ready;
  assign q_ready = adv;

  // restoring divider: one quotient bit per stage, (dbl << 30) / W
  logic [32:0] drem [DS+1];
  logic [29:0] rq   [DS+1];

  always_comb begin
    drem[0] = q_item.dbl;
    rq[0]   = 30'd0;
  end

  genvar g;
  generate
    for (g = 0; g < DS; g++) begin : g_div
      logic [33:0] trial;
      always_comb trial = {drem[g], 1'b0};
      always_ff @(posedge clk) begin
        if (adv) begin
          if (trial >= {2'b0, width}) begin
            drem[g+1] <= 33'(trial - {2'b0, width});
            rq[g+1]   <= {rq[g][28:0], 1'b1};
          end else begin
            drem[g+1] <= trial[32:0];
            rq[g+1]   <= {rq[g][28:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // u = 2^30 - r*r>>30
  logic [30:0] u0;
  always_ff @(posedge clk) begin
    if (adv) u0 <= 31'(31'h4000_0000 - 31'(({30'd0, rq[DS]} * {30'd0, rq[DS]}) >> FracW));
  end

  // Horner: one multiply per stage
  logic [33:0] acc [HS+1];
  logic [30:0] uu  [HS+1];
  always_comb begin
    acc[0] = {2'b0, KTop};
    uu[0]  = u0;
  end
  generate
    for (g = 0; g < HS; g++) begin : g_hor
      localparam logic [31:0] KAdd = coef(T-1-g);
      logic [64:0] p;
      always_comb p = {31'd0, acc[g]} * {34'd0, uu[g]};
      always_ff @(posedge clk) begin
        if (adv) begin
          uu[g+1]  <= uu[g];
          if (g == HS-1) acc[g+1] <= 34'(p >> FracW);
          else acc[g+1] <= 34'(p >> FracW) + {2'b0, KAdd};
        end
      end
    end
  endgenerate

  logic [34:0] rnd;
  always_comb rnd = ({1'b0, acc[HS]} + 35'd2) >> 2;

  // control shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], q_valid};
    end
    if (adv) begin
      zr <= {zr[NS-2:0], q_item.zero};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= vld[NS-1];
    end
    if (adv) begin
      if (zr[NS-1] || uu[HS] == 31'd0) out_ch.data <= '0;
      else if (rnd > {4'd0, OneQ30}) out_ch.data <= OneQ30;
      else out_ch.data <= rnd[30:0];
    end
  end
endmodule

[rtl/core/modified_kaiser_bessel_window.sv]
// Channel     Dir   Payload                          Handshake
// in_ch       in    position, signed Q16.16          valid/ready
// out_ch      out   window_value, unsigned Q2.30     valid/ready
// cfg         in    window_width, Q16.16             cfg_we, no wait
//
// One transfer per cycle sustained while out_ch accepts; each transfer
// passes the front register, a queue slot, 30 one-bit divider stages,
// the square stage, one Horner multiply per term and the output register.
// rst is synchronous and clears all valid flags; width resets to 1.0.
// A stall on out_ch freezes the back pipeline; the two-entry queue keeps
// the front accepting until it fills.
module modified_kaiser_bessel_window #(
  parameter int TERMS = mkbw_pkg::DefTerms
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  mkbw_if.sink        in_ch,
  mkbw_if.source      out_ch
);
  import mkbw_pkg::*;

  logic [31:0] width;
  logic        f_valid, f_ready, b_valid, b_ready;
  mkbw_item_t  f_item, b_item;

  always_ff @(posedge clk) begin
    if (rst) width <= WidthReset;
    else if (cfg_we) width <= cfg_data;
  end

  mkbw_front u_front (
    .clk, .rst, .width, .in_ch,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  mkbw_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  mkbw_back #(.TERMS(TERMS)) u_back (
    .clk, .rst, .width,
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item), .out_ch
  );
endmodule
